@@ hw/rtl/orma_pkg.sv @@
// Shared constants, types and the divide-by-window helper for the outlier-rejecting average.
package orma_pkg;

	localparam int unsigned SAMPLES = 8;
	localparam int unsigned DATA_W = 10;
	localparam int unsigned TDATA_W = 16;
	localparam int unsigned SLOT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
	localparam int unsigned DIV_L = $clog2(SAMPLES);
	localparam int unsigned SUM_W = $clog2(SAMPLES * 1023 + 1);

	// floor(s / SAMPLES) == (s * RECIP) >> DIV_SHIFT for every s below 2**SUM_W
	localparam int unsigned DIV_SHIFT = SUM_W + DIV_L;
	localparam int unsigned RECIP_W = SUM_W + 1;
	localparam int unsigned PROD_W = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

	localparam logic [DATA_W-1:0] LOW_LIMIT_RESET = 10'd58;
	localparam logic [DATA_W-1:0] HIGH_LIMIT_RESET = 10'd120;

	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 1'b1;

	typedef struct packed {
		logic [DATA_W-1:0] kept;
		logic replaced;
	} keep_t;

	function automatic logic [DATA_W-1:0] window_mean(input logic [SUM_W-1:0] sum);
		logic [PROD_W-1:0] prod;
		prod = {{RECIP_W{1'b0}}, sum} * {{SUM_W{1'b0}}, RECIP};
		return prod[DIV_SHIFT +: DATA_W];
	endfunction

endpackage

@@ hw/rtl/orma_filter.sv @@
// Limit check: keep the sample or substitute the previously kept value.
module orma_filter (
	input  logic [orma_pkg::DATA_W-1:0] sample,
	input  logic [orma_pkg::DATA_W-1:0] low_limit,
	input  logic [orma_pkg::DATA_W-1:0] high_limit,
	input  logic [orma_pkg::DATA_W-1:0] last_kept,
	output orma_pkg::keep_t             result
);

	logic reject;

	// both bounds are inclusive; crossed limits reject everything
	assign reject = (sample > high_limit) || (sample < low_limit);

	always_comb begin
		result.replaced = reject;
		result.kept = reject ? last_kept : sample;
	end

endmodule

@@ hw/rtl/orma_ring.sv @@
// Ring of kept samples with write slot, running sum and last kept value.
module orma_ring (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [orma_pkg::DATA_W-1:0] kept,
	output logic [orma_pkg::SUM_W-1:0]  sum_next,
	output logic [orma_pkg::DATA_W-1:0] last_kept
);

	logic [orma_pkg::DATA_W-1:0] ring_q [orma_pkg::SAMPLES];
	logic [orma_pkg::SLOT_W-1:0] slot_q;
	logic [orma_pkg::SUM_W-1:0] sum_q;
	logic [orma_pkg::DATA_W-1:0] last_q;
	logic [orma_pkg::SLOT_W-1:0] slot_next;

	assign sum_next = sum_q - orma_pkg::SUM_W'(ring_q[slot_q]) + orma_pkg::SUM_W'(kept);
	assign slot_next = (slot_q == orma_pkg::SLOT_W'(orma_pkg::SAMPLES - 1)) ?
		'0 : slot_q + orma_pkg::SLOT_W'(1);
	assign last_kept = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < orma_pkg::SAMPLES; i++) begin
				ring_q[i] <= '0;
			end
			slot_q <= '0;
			sum_q <= '0;
			last_q <= '0;
		end else if (wr_en) begin
			ring_q[slot_q] <= kept;
			slot_q <= slot_next;
			sum_q <= sum_next;
			last_q <= kept;
		end
	end

endmodule

@@ hw/rtl/outlier_rejecting_moving_average.sv @@
// Top level: outlier-rejecting moving average over a ring of kept sonar samples.
//
// Input stream (s_axis_*): one beat carries one raw 10-bit sample in tdata[9:0].
// Output stream (m_axis_*): one beat per input beat, in order; tdata[9:0] is the
// truncated mean of the SAMPLES ring slots after the update, tuser[0] is set when
// the sample fell outside [low_limit, high_limit] and the previous kept value
// was stored in its place.
// Configuration: cfg_we with cfg_index 0 writes low_limit, index 1 writes
// high_limit (both 10 bits). Write only while the block holds no beat in flight.
// Datapath: an input register, then one pass of limit check, ring/sum update and
// reciprocal-multiply divide into the output register.
// Throughput: one beat per cycle while m_axis_tready stays high, set by the ring and sum update being done in one pass.
// Reset: arst_n clears the ring, running sum, write slot and last kept value to
// zero and loads the limits with 58 and 120; both stages come up empty.
// Stall: when m_axis_tready is low with a result waiting, the input register still
// takes one more beat if it is empty, then s_axis_tready drops; nothing is lost or repeated.
module outlier_rejecting_moving_average (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [orma_pkg::TDATA_W-1:0]   s_axis_tdata,   // [9:0] sample
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [orma_pkg::TDATA_W-1:0]   m_axis_tdata,   // [9:0] average
	output logic                           m_axis_tuser,   // [0] replaced
	input  logic                           cfg_we,
	input  logic [orma_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [orma_pkg::DATA_W-1:0]    cfg_data
);

	logic [orma_pkg::DATA_W-1:0] low_limit_q;
	logic [orma_pkg::DATA_W-1:0] high_limit_q;

	logic valid_s1;
	logic [orma_pkg::DATA_W-1:0] sample_s1;

	logic valid_s2;
	logic [orma_pkg::DATA_W-1:0] average_s2;
	logic replaced_s2;

	logic out_free;
	logic advance;
	logic in_fire;
	orma_pkg::keep_t keep;
	logic [orma_pkg::DATA_W-1:0] last_kept;
	logic [orma_pkg::SUM_W-1:0] sum_next;

	// Result register frees up when empty or when its beat is taken this cycle.
	assign out_free = !valid_s2 || m_axis_tready;
	// Move the input-stage beat through the update only into a free result slot.
	assign advance = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	// Limits: plain write port, no read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_limit_q <= orma_pkg::LOW_LIMIT_RESET;
			high_limit_q <= orma_pkg::HIGH_LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				orma_pkg::REG_LOW_LIMIT: low_limit_q <= cfg_data;
				orma_pkg::REG_HIGH_LIMIT: high_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register: hold while the beat waits for the result slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_s1 <= s_axis_tdata[orma_pkg::DATA_W-1:0];
		end
	end

	orma_filter u_filter (
		.sample     (sample_s1),
		.low_limit  (low_limit_q),
		.high_limit (high_limit_q),
		.last_kept  (last_kept),
		.result     (keep)
	);

	// Ring state commits exactly once per beat, when it enters the result register.
	orma_ring u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (advance),
		.kept      (keep.kept),
		.sum_next  (sum_next),
		.last_kept (last_kept)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			average_s2 <= orma_pkg::window_mean(sum_next);
			replaced_s2 <= keep.replaced;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata = {{(orma_pkg::TDATA_W - orma_pkg::DATA_W){1'b0}}, average_s2};
	assign m_axis_tuser = replaced_s2;

endmodule
